[hw/rtl/lri_pkg.sv]
package lri_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned CNT_W  = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] LFSR_RESET = 16'd10;
    localparam logic [DATA_W-1:0] TAP_BIT15  = 16'h8000;
    localparam logic [DATA_W-1:0] TAP_BIT14  = 16'h4000;
    localparam logic [DATA_W-1:0] TAP_BIT12  = 16'h1000;
    localparam logic [DATA_W-1:0] TAP_BIT3   = 16'h0008;

    typedef struct packed {
        logic [DATA_W-1:0] range_start;
        logic [DATA_W-1:0] range_stop;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] random_value;
        logic [DATA_W-1:0] raw_lfsr;
        logic              range_empty;
    } out_item_t;

    typedef struct packed {
        logic start;
    } mod_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

[hw/rtl/lri_lfsr.sv]
module lri_lfsr
    import lri_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    output logic [DATA_W-1:0] word
);

    logic [DATA_W-1:0] lfsr_reg;
    logic [DATA_W-1:0] lfsr_next;
    logic [DATA_W-1:0] seed;
    logic              fb;

    always_comb begin
        // an all-zero word would lock up, so it restarts from one
        seed = (lfsr_reg == '0) ? {{(DATA_W-1){1'b0}}, 1'b1} : lfsr_reg;
        fb   = (|(seed & TAP_BIT15)) ^ (|(seed & TAP_BIT14))
             ^ (|(seed & TAP_BIT12)) ^ (|(seed & TAP_BIT3));
        lfsr_next = step ? {seed[DATA_W-2:0], fb} : lfsr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= LFSR_RESET;
        end else begin
            lfsr_reg <= lfsr_next;
        end
    end

    assign word = lfsr_reg;

endmodule

[hw/rtl/lri_mod_unit.sv]
module lri_mod_unit
    import lri_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  mod_ctrl_t         ctrl,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output mod_stat_t         stat,
    output logic [DATA_W-1:0] remainder
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W+1:0] diff;

    // one restoring remainder step per cycle, MSB of the dividend first
    always_comb begin
        trial     = {rem_reg, dvd_reg[DATA_W-1]};
        diff      = {1'b0, trial} - {2'b00, dsr_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = diff[DATA_W+1] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/lfsr_random_in_range.sv]
// Pseudorandom value in a requested range. Each request steps a 16-bit
// Fibonacci LFSR (taps 15, 14, 12, 3, reset value 10, a zero word restarts
// at one) and returns range_start + (LFSR mod |range_stop - range_start|)
// wrapped to 16 bits, together with the raw LFSR word. When start equals
// stop, range_empty is set and random_value is range_start. One request is
// handled at a time: s_ready is high only while idle, and a request passes
// through a load state, the one-bit-per-cycle remainder unit, its done flag
// and the final add before m_valid, and waits longer if the previous result
// has not been taken.
module lfsr_random_in_range
    import lri_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] start_reg, start_next;
    logic [DATA_W-1:0] span_reg, span_next;
    logic              empty_reg, empty_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         out_reg, out_next;

    logic              accept;
    logic              out_free;
    logic              lfsr_step;
    logic [DATA_W-1:0] lfsr_word;
    logic [DATA_W-1:0] remainder;
    mod_ctrl_t         mod_ctrl;
    mod_stat_t         mod_stat;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    lri_lfsr u_lfsr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (lfsr_step),
        .word    (lfsr_word)
    );

    lri_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (mod_ctrl),
        .dividend  (lfsr_word),
        .divisor   (span_reg),
        .stat      (mod_stat),
        .remainder (remainder)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (mod_stat.done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready        = 1'b0;
        lfsr_step      = 1'b0;
        mod_ctrl.start = 1'b0;
        start_next     = start_reg;
        span_next      = span_reg;
        empty_next     = empty_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    lfsr_step  = 1'b1;
                    start_next = s_data.range_start;
                    span_next  = (s_data.range_stop >= s_data.range_start)
                               ? s_data.range_stop - s_data.range_start
                               : s_data.range_start - s_data.range_stop;
                    empty_next = (s_data.range_stop == s_data.range_start);
                end
            end
            ST_LOAD: mod_ctrl.start = 1'b1;
            ST_DIV:  ;
            ST_DONE: begin
                if (out_free) begin
                    out_next.random_value = empty_reg ? start_reg : start_reg + remainder;
                    out_next.raw_lfsr     = lfsr_word;
                    out_next.range_empty  = empty_reg;
                    m_valid_next          = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        span_reg  <= span_next;
        empty_reg <= empty_next;
        out_reg   <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_LOAD) && mod_stat.busy == 1'b0)
        else $error("accepted request did not move to load");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_stat.done |-> (state_reg == ST_DIV))
        else $error("remainder done outside divide state");

    a_busy_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_stat.busy |-> (state_reg == ST_DIV))
        else $error("remainder unit busy outside divide state");

    a_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.raw_lfsr != '0))
        else $error("raw LFSR word is zero");
`endif

endmodule

[tb/lfsr_random_in_range_test.sv]
`timescale 1ns / 1ps

module lfsr_random_in_range_test;
    import lri_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    logic [DATA_W-1:0] lfsr_model;
    out_item_t         pending_draws[$];
    int                mismatch_count     = 0;
    bit                sender_gaps_on     = 1'b0;
    bit                receiver_stalls_on = 1'b0;
    int                stall_left         = 0;

    lfsr_random_in_range i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("lfsr_random_in_range_test: FAIL");
        $finish;
    end

    // Steps the local LFSR copy and works out the draw for one request.
    function automatic out_item_t predict_draw(in_item_t req);
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] span;
        logic              feedback;
        out_item_t         res;
        word = (lfsr_model == '0) ? DATA_W'(1) : lfsr_model;
        feedback = ((word & TAP_BIT15) != '0) ^ ((word & TAP_BIT14) != '0)
                 ^ ((word & TAP_BIT12) != '0) ^ ((word & TAP_BIT3) != '0);
        word = {word[DATA_W-2:0], feedback};
        lfsr_model = word;
        if (req.range_stop >= req.range_start)
            span = req.range_stop - req.range_start;
        else
            span = req.range_start - req.range_stop;
        res.raw_lfsr = word;
        if (span == '0) begin
            res.range_empty  = 1'b1;
            res.random_value = req.range_start;
        end else begin
            res.range_empty  = 1'b0;
            res.random_value = DATA_W'(req.range_start + word % span);
        end
        return res;
    endfunction

    // Result side back-pressure: bursts of stalled cycles of random length.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (receiver_stalls_on && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_draws.size() == 0) begin
                $display("%0t: result with no request outstanding: %p", $time, m_data);
                mismatch_count++;
            end else begin
                want = pending_draws.pop_front();
                if (m_data.random_value !== want.random_value) begin
                    $display("%0t: random_value expected %h actual %h",
                             $time, want.random_value, m_data.random_value);
                    mismatch_count++;
                end
                if (m_data.raw_lfsr !== want.raw_lfsr) begin
                    $display("%0t: raw_lfsr expected %h actual %h",
                             $time, want.raw_lfsr, m_data.raw_lfsr);
                    mismatch_count++;
                end
                if (m_data.range_empty !== want.range_empty) begin
                    $display("%0t: range_empty expected %b actual %b",
                             $time, want.range_empty, m_data.range_empty);
                    mismatch_count++;
                end
            end
        end
    end

    // Valid is left high between back-to-back requests; it only drops for a gap or in hold_until_drained.
    task automatic send_request(input logic [DATA_W-1:0] range_start,
                                input logic [DATA_W-1:0] range_stop);
        in_item_t req;
        req.range_start = range_start;
        req.range_stop  = range_stop;
        if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_draws.push_back(predict_draw(req));
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic test_range_extremes();
        send_request(16'h0000, 16'hFFFF);
        send_request(16'hFFFF, 16'h0000);
        send_request(16'h0000, 16'h0001);
        send_request(16'h0001, 16'h0000);
        send_request(16'hFFFE, 16'hFFFF);
        send_request(16'h8000, 16'h7FFF);
        send_request(16'h5555, 16'hAAAA);
        send_request(16'hAAAA, 16'h5555);
    endtask

    task automatic test_empty_range();
        send_request(16'h0000, 16'h0000);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'h1234, 16'h1234);
        send_request(16'h8000, 16'h8000);
    endtask

    // start above stop; large starts make the sum wrap past 16 bits
    task automatic test_stop_below_start();
        send_request(16'd100, 16'd3);
        send_request(16'hFFFF, 16'h0001);
        send_request(16'hFFF0, 16'h0010);
        send_request(16'hC000, 16'h4000);
        send_request(16'h0002, 16'h0001);
    endtask

    task automatic test_pause_for_results();
        send_request(16'h0010, 16'h0400);
        hold_until_drained();
        send_request(16'h7FFF, 16'h0000);
        hold_until_drained();
        send_request(16'h0300, 16'h0300);
        hold_until_drained();
    endtask

    task automatic test_random_draws(input int count);
        logic [DATA_W-1:0] lo_end;
        logic [DATA_W-1:0] hi_end;
        int                i;
        for (i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                // idling comes and goes in stretches, and stops for the tail
                sender_gaps_on     = (i < count - 200) && ($urandom_range(0, 3) != 0);
                receiver_stalls_on = (i < count - 200) && ($urandom_range(0, 3) != 0);
                if (i > 0 && $urandom_range(0, 2) == 0)
                    hold_until_drained();
            end
            lo_end = DATA_W'($urandom);
            hi_end = DATA_W'($urandom);
            case ($urandom_range(0, 9))
                5, 6: hi_end = lo_end + DATA_W'($urandom_range(1, 16));
                7:    hi_end = lo_end - DATA_W'($urandom_range(1, 16));
                8:    hi_end = lo_end;
                9:    lo_end = ($urandom_range(0, 1) != 0) ? '1 : '0;
                default: ;
            endcase
            send_request(lo_end, hi_end);
        end
    endtask

    initial begin
        lfsr_model = LFSR_RESET;
        repeat (12) @(posedge aclk);
        aresetn            <= 1'b1;
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;

        test_range_extremes();
        test_empty_range();
        test_stop_below_start();
        test_pause_for_results();
        test_random_draws(1450);

        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
        repeat (25) @(posedge aclk);

        if (mismatch_count == 0)
            $display("lfsr_random_in_range_test: PASS");
        else
            $display("lfsr_random_in_range_test: FAIL");
        $finish;
    end

endmodule
